FILE: src/dstf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstf_pkg
// Shared constants, types and tables for the decimal string to fixed point
// converter.
// ----------------------------------------------------------------------------
package dstf_pkg;

  // Number format
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int INT_BITS        = 31;

  // Width of the clamped magnitude
  localparam int RES_BITS = (INT_BITS + FRAC_BITS > 47) ? 47 : (INT_BITS + FRAC_BITS);

  localparam int VALUE_W = 48;
  localparam int MANT_W  = 64;
  localparam int NUM_W   = MANT_W + FRAC_BITS;   // dividend and quotient width
  localparam int P_W     = 50;                   // holds 10^15
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int FD_W    = 4;

  // Character codes
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Kind of the previous accepted character
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DOT   = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic char_load;
    logic end_load;
    logic div_step;
    logic res_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

  // Powers of ten used as divisor
  function automatic logic [P_W-1:0] pow10(input logic [FD_W-1:0] n);
    logic [P_W-1:0] p;
    case (n)
      4'd0:    p = P_W'(64'd1);
      4'd1:    p = P_W'(64'd10);
      4'd2:    p = P_W'(64'd100);
      4'd3:    p = P_W'(64'd1000);
      4'd4:    p = P_W'(64'd10000);
      4'd5:    p = P_W'(64'd100000);
      4'd6:    p = P_W'(64'd1000000);
      4'd7:    p = P_W'(64'd10000000);
      4'd8:    p = P_W'(64'd100000000);
      4'd9:    p = P_W'(64'd1000000000);
      4'd10:   p = P_W'(64'd10000000000);
      4'd11:   p = P_W'(64'd100000000000);
      4'd12:   p = P_W'(64'd1000000000000);
      4'd13:   p = P_W'(64'd10000000000000);
      4'd14:   p = P_W'(64'd100000000000000);
      4'd15:   p = P_W'(64'd1000000000000000);
      default: p = P_W'(64'd1);
    endcase
    return p;
  endfunction

endpackage

FILE: src/dstf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstf_ctrl
// Controller: takes characters, runs the closing division, hands the result
// to the output register.
// ----------------------------------------------------------------------------
module dstf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  end_of_string,
  output logic                  in_ready,
  input  dstf_pkg::dp_status_t  status,
  output dstf_pkg::dp_cmd_t     cmd
);
  import dstf_pkg::*;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_ACCEPT);
  assign accept   = in_valid && in_ready;

  // Decode commands
  always_comb begin
    cmd.char_load = accept && !end_of_string;
    cmd.end_load  = accept && end_of_string;
    cmd.div_step  = (state == ST_DIVIDE) && !status.div_done;
    cmd.res_load  = (state == ST_FINISH) && status.out_free;
  end

  // Advance state
  always_comb begin
    state_next = state;
    case (state)
      ST_ACCEPT: begin
        if (accept && end_of_string) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_ACCEPT;
      end
      default: state_next = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/dstf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstf_datapath
// Character parser, mantissa accumulator, bit-serial divider by a power of
// ten and output register.
// ----------------------------------------------------------------------------
module dstf_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  char_code,
  input  dstf_pkg::dp_cmd_t           cmd,
  output dstf_pkg::dp_status_t        status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [dstf_pkg::VALUE_W-1:0] value,
  output logic                        invalid,
  output logic                        saturated
);
  import dstf_pkg::*;

  // Parser state
  logic              phase;
  kind_t             prev_kind;
  logic              dot_seen;
  logic              is_negative;
  logic              number_stopped;
  logic [MANT_W-1:0] mantissa;
  logic [FD_W-1:0]   frac_digits;
  logic              invalid_flag;
  logic              overflow_flag;

  logic              phase_next;
  kind_t             prev_kind_next;
  logic              dot_seen_next;
  logic              is_negative_next;
  logic              number_stopped_next;
  logic [MANT_W-1:0] mantissa_next;
  logic [FD_W-1:0]   frac_digits_next;
  logic              invalid_flag_next;
  logic              overflow_flag_next;

  // Divider state
  logic [NUM_W-1:0]  num;
  logic [P_W-1:0]    rem;
  logic [P_W-1:0]    divisor;
  logic [CNT_W-1:0]  cnt;
  logic              res_neg;
  logic              res_inv;
  logic              res_ovf;

  logic              is_digit;
  logic              is_dot;
  logic              is_sign;
  logic              allowed;
  logic              skip;
  logic [MANT_W+3:0] mac;
  logic              mac_ovf;
  logic [P_W:0]      rem_sh;
  logic [P_W:0]      rem_diff;
  logic              rem_ge;
  logic              quot_hi;
  logic [RES_BITS-1:0] mag;
  logic [VALUE_W-1:0]  mag_ext;

  // Classify the character
  always_comb begin
    is_digit = (char_code inside {[CH_0:CH_9]});
    is_dot   = (char_code == CH_DOT);
    is_sign  = (char_code inside {CH_MINUS, CH_PLUS});
    allowed  = is_digit || is_dot || is_sign || (char_code inside {CH_NEWLINE, CH_SPACE});
    skip     = !phase && (char_code == CH_SPACE);
  end

  // Multiply by ten and add the digit
  assign mac = ({4'b0, mantissa} << 3) + ({4'b0, mantissa} << 1)
             + (MANT_W+4)'(char_code[3:0]);
  assign mac_ovf = |mac[MANT_W+3:MANT_W];

  // Parser next state
  always_comb begin
    phase_next          = phase;
    prev_kind_next      = prev_kind;
    dot_seen_next       = dot_seen;
    is_negative_next    = is_negative;
    number_stopped_next = number_stopped;
    mantissa_next       = mantissa;
    frac_digits_next    = frac_digits;
    invalid_flag_next   = invalid_flag;
    overflow_flag_next  = overflow_flag;
    if (!skip) begin
      phase_next = 1'b1;
      if (!allowed) begin
        invalid_flag_next = 1'b1;
      end else if (is_dot) begin
        if (dot_seen) invalid_flag_next = 1'b1;
        dot_seen_next = 1'b1;
      end else if (is_sign && prev_kind == KIND_OTHER) begin
        invalid_flag_next = 1'b1;
      end
      prev_kind_next = is_dot ? KIND_DOT : KIND_OTHER;
      if (!number_stopped) begin
        if (!phase && is_sign) begin
          if (char_code == CH_MINUS) is_negative_next = 1'b1;
        end else if (is_digit) begin
          if (!dot_seen || frac_digits < FD_W'(MAX_FRAC_DIGITS)) begin
            if (dot_seen) frac_digits_next = frac_digits + 1'b1;
            mantissa_next      = mac_ovf ? '1 : mac[MANT_W-1:0];
            overflow_flag_next = overflow_flag | mac_ovf;
          end
        end else if (!is_dot) begin
          number_stopped_next = 1'b1;
        end
      end
    end
  end

  // Update parser; clear it when the string closes
  always_ff @(posedge clk) begin
    if (rst || cmd.end_load) begin
      phase          <= 1'b0;
      prev_kind      <= KIND_NONE;
      dot_seen       <= 1'b0;
      is_negative    <= 1'b0;
      number_stopped <= 1'b0;
      mantissa       <= '0;
      frac_digits    <= '0;
      invalid_flag   <= 1'b0;
      overflow_flag  <= 1'b0;
    end else if (cmd.char_load) begin
      phase          <= phase_next;
      prev_kind      <= prev_kind_next;
      dot_seen       <= dot_seen_next;
      is_negative    <= is_negative_next;
      number_stopped <= number_stopped_next;
      mantissa       <= mantissa_next;
      frac_digits    <= frac_digits_next;
      invalid_flag   <= invalid_flag_next;
      overflow_flag  <= overflow_flag_next;
    end
  end

  // One restoring division step
  always_comb begin
    rem_sh   = {rem, num[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    rem_ge   = (rem_sh >= {1'b0, divisor});
  end

  // Divider counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.end_load) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cmd.div_step) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Divider data: quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (cmd.end_load) begin
      num     <= NUM_W'(mantissa) << FRAC_BITS;
      rem     <= '0;
      divisor <= pow10(frac_digits);
      res_neg <= is_negative;
      res_inv <= invalid_flag;
      res_ovf <= overflow_flag;
    end else if (cmd.div_step) begin
      num <= {num[NUM_W-2:0], rem_ge};
      rem <= rem_ge ? rem_diff[P_W-1:0] : rem_sh[P_W-1:0];
    end
  end

  // Clamp the quotient and extend it to the output width
  always_comb begin
    quot_hi = |num[NUM_W-1:RES_BITS];
    mag     = quot_hi ? '1 : num[RES_BITS-1:0];
    mag_ext = VALUE_W'(mag);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (res_inv) begin
        value     <= '0;
        invalid   <= 1'b1;
        saturated <= 1'b0;
      end else begin
        value     <= res_neg ? -$signed(mag_ext) : $signed(mag_ext);
        invalid   <= 1'b0;
        saturated <= res_ovf | quot_hi;
      end
    end
  end

  assign status.div_done = (cnt == '0);
  assign status.out_free = !out_valid || out_ready;

  // Checks
  a_ovf_sticks: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (&mantissa))
    else $error("overflow set without saturated mantissa");

  a_frac_limit: assert property (@(posedge clk) disable iff (rst)
    frac_digits <= FD_W'(MAX_FRAC_DIGITS))
    else $error("fraction digit count beyond limit");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && invalid) |-> (value == '0 && !saturated))
    else $error("invalid result carries a value");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.end_load |=> (mantissa == '0 && !invalid_flag && !phase && cnt == CNT_W'(NUM_W)))
    else $error("parser not cleared at end of string");

endmodule

FILE: src/decimal_string_to_fixed_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_top
// Converts an ASCII decimal string, one character per request, into signed
// fixed point with invalid and saturation flags.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while no conversion is in progress. An
// end-of-string request starts a bit-serial division by a power of ten, one
// quotient bit per cycle over 64 + FRAC_BITS bits; the result is then loaded
// into the output register once it is free, and no request is taken meanwhile.
// Reset clears the parser, the divider counter and the output valid.
module decimal_string_to_fixed_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  char_code,
  input  logic                        end_of_string,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [dstf_pkg::VALUE_W-1:0] value,
  output logic                        invalid,
  output logic                        saturated
);
  import dstf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the work
  dstf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .end_of_string (end_of_string),
    .in_ready      (in_ready),
    .status        (status),
    .cmd           (cmd)
  );

  // Parse, divide and hold the result
  dstf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .invalid   (invalid),
    .saturated (saturated)
  );

endmodule

FILE: dv/tb_decimal_string_to_fixed_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_string_to_fixed_top
// Self-checking bench for the decimal string to fixed point converter: feeds
// short strings and random character streams, predicts each end-of-string
// result with an independent parser model and compares every result field.
// ----------------------------------------------------------------------------
module tb_decimal_string_to_fixed_top;
  import dstf_pkg::*;

  localparam int ITEM_TARGET = 1400;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 200;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      invalid;
    logic                      saturated;
  } number_result_t;

  // Parser model and store of expected numbers
  class decimal_parse_checker;
    bit                  started;
    kind_t               prev_kind;
    bit                  dot_seen;
    bit                  neg;
    bit                  stopped;
    logic [MANT_W-1:0]   mant;
    int                  frac_digits;
    bit                  bad;
    bit                  ovf;
    number_result_t      expected_numbers[$];
    int                  errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      started     = 0;
      prev_kind   = KIND_NONE;
      dot_seen    = 0;
      neg         = 0;
      stopped     = 0;
      mant        = '0;
      frac_digits = 0;
      bad         = 0;
      ovf         = 0;
    endfunction

    // Append a decimal digit, sticking at all ones on overflow
    function void push_digit(logic [7:0] c);
      logic [127:0] wide;
      wide = {64'd0, mant} * 128'd10 + 128'(c - CH_0);
      if (wide > 128'({MANT_W{1'b1}})) begin
        mant = '1;
        ovf  = 1;
      end else begin
        mant = wide[MANT_W-1:0];
      end
    endfunction

    // Scale the mantissa to fixed point, clamp and apply the sign
    function number_result_t close_number();
      number_result_t r;
      logic [127:0]   pw;
      logic [127:0]   quot;
      logic [127:0]   rem;
      logic [127:0]   mag;
      logic [127:0]   max_mag;
      logic [VALUE_W-1:0] m48;
      r       = '0;
      max_mag = (128'd1 << RES_BITS) - 128'd1;
      if (bad) begin
        r.invalid = 1'b1;
        return r;
      end
      pw = 128'd1;
      for (int i = 0; i < frac_digits && i < 15; i++) pw = pw * 128'd10;
      quot        = {64'd0, mant} / pw;
      rem         = {64'd0, mant} % pw;
      r.saturated = ovf;
      if (quot > (max_mag >> FRAC_BITS)) begin
        mag         = max_mag;
        r.saturated = 1'b1;
      end else begin
        mag = (quot << FRAC_BITS) | ((rem << FRAC_BITS) / pw);
      end
      m48     = mag[VALUE_W-1:0];
      r.value = neg ? -m48 : m48;
      return r;
    endfunction

    // Note an accepted request and advance the parser
    function void take_char(logic [7:0] c, logic eos);
      bit is_lead;
      bit is_digit;
      bit is_dot;
      bit is_sign;
      bit allowed;
      if (eos) begin
        expected_numbers.push_back(close_number());
        clear_parse();
        return;
      end
      if (!started && c == CH_SPACE) return;
      is_lead = !started;
      started = 1;

      is_digit = (c >= CH_0 && c <= CH_9);
      is_dot   = (c == CH_DOT);
      is_sign  = (c == CH_MINUS || c == CH_PLUS);
      allowed  = is_digit || is_dot || is_sign || c == CH_NEWLINE || c == CH_SPACE;

      // Validation runs over the whole string
      if (!allowed) begin
        bad = 1;
      end else if (is_dot) begin
        if (dot_seen) bad = 1;
        dot_seen = 1;
      end else if (is_sign && prev_kind == KIND_OTHER) begin
        bad = 1;
      end
      prev_kind = is_dot ? KIND_DOT : KIND_OTHER;

      // Number building stops at the first foreign character
      if (!stopped) begin
        if (is_lead && is_sign) begin
          if (c == CH_MINUS) neg = 1;
        end else if (is_digit) begin
          if (dot_seen) begin
            if (frac_digits < MAX_FRAC_DIGITS) begin
              frac_digits++;
              push_digit(c);
            end
          end else begin
            push_digit(c);
          end
        end else if (!is_dot) begin
          stopped = 1;
        end
      end
    endfunction

    // Compare one result with the oldest expected number
    function void check_result(logic signed [VALUE_W-1:0] value, logic invalid,
                               logic saturated);
      number_result_t e;
      if (expected_numbers.size() == 0) begin
        $error("unexpected result: value %0d invalid %0b saturated %0b",
               value, invalid, saturated);
        errors++;
        return;
      end
      e = expected_numbers.pop_front();
      if (value !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, value);
        errors++;
      end
      if (invalid !== e.invalid) begin
        $error("invalid: expected %0b, got %0b", e.invalid, invalid);
        errors++;
      end
      if (saturated !== e.saturated) begin
        $error("saturated: expected %0b, got %0b", e.saturated, saturated);
        errors++;
      end
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction
  endclass

  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic [7:0]                char_code     = 8'h00;
  logic                      end_of_string = 1'b0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic                      invalid;
  logic                      saturated;

  decimal_parse_checker sb = new();

  int tx_idle_pct = 38;
  int rx_idle_pct = 46;
  int items_sent  = 0;
  int quiet_cycles = 0;
  bit hold_go     = 0;

  decimal_string_to_fixed_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value         (value),
    .invalid       (invalid),
    .saturated     (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    static int  hold_cnt  = 0;
    static bit  hold_done = 0;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_go && !hold_done) begin
        hold_done = 1;
        hold_cnt  = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Track accepted requests and results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.take_char(char_code, end_of_string);
      if (out_valid && out_ready) sb.check_result(value, invalid, saturated);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one request, idling at random first
  task automatic send_req(input logic [7:0] c, input logic eos);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    char_code     <= c;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send a string and its end request; ignored leading spaces are not counted
  task automatic send_string(input char_q_t s);
    bit lead = 1'b1;
    foreach (s[i]) begin
      if (!(lead && s[i] == CH_SPACE)) begin
        lead = 1'b0;
        items_sent++;
      end
      send_req(s[i], 1'b0);
    end
    send_req(8'($urandom_range(0, 255)), 1'b1);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  // Pick a character that tends to break or stop a number
  function automatic logic [7:0] rand_symbol();
    case ($urandom_range(0, 6))
      0:       return CH_DOT;
      1:       return CH_MINUS;
      2:       return CH_PLUS;
      3:       return CH_SPACE;
      4:       return CH_NEWLINE;
      5:       return rand_digit();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed numbers, some broken ones, some noise
  function automatic char_q_t make_text();
    char_q_t s;
    int      mode;
    int      n;
    mode = $urandom_range(0, 99);
    if (mode < 85) begin
      repeat ($urandom_range(0, 3)) s.push_back(CH_SPACE);
      case ($urandom_range(0, 3))
        0:       s.push_back(CH_MINUS);
        1:       s.push_back(CH_PLUS);
        default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      repeat (n) s.push_back(rand_digit());
      if ($urandom_range(0, 9) < 6) begin
        s.push_back(CH_DOT);
        repeat ($urandom_range(0, 12)) s.push_back(rand_digit());
      end
      if ($urandom_range(0, 4) == 0) begin
        s.push_back($urandom_range(0, 1) ? CH_NEWLINE : CH_SPACE);
        repeat ($urandom_range(0, 2)) s.push_back(rand_digit());
      end
      if (mode >= 70) s.insert($urandom_range(0, s.size()), rand_symbol());
    end else begin
      repeat ($urandom_range(0, 8)) begin
        s.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : rand_symbol());
      end
    end
    return s;
  endfunction

  initial begin
    char_q_t empty_text;
    bit      paused = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty string, leading space with minus and fraction, plus sign,
    // second dot, sign after a digit, zero byte, top byte, minus zero, newline
    send_string(empty_text);
    send_string('{CH_SPACE, CH_MINUS, CH_0 + 8'd1, CH_DOT, CH_0 + 8'd5});
    send_string('{CH_PLUS, CH_9});
    send_string('{CH_DOT, CH_DOT});
    send_string('{CH_0 + 8'd1, CH_MINUS});
    send_string('{8'h00});
    send_string('{8'hFF});
    send_string('{CH_MINUS, CH_0});
    send_string('{CH_0 + 8'd7, CH_NEWLINE});

    // Random: three idling profiles, one long receiver hold, one full drain
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 930) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (items_sent >= 470) begin
        tx_idle_pct = 46;
        rx_idle_pct = 38;
      end
      if (items_sent >= 250) hold_go = 1;
      if (!paused && items_sent >= 700) begin
        paused = 1;
        in_valid <= 1'b0;
        // Let the last end request reach the scoreboard before polling it
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_string(make_text());
    end
    in_valid <= 1'b0;

    // Drain and let any stray result show up
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: decimal_string_to_fixed_top.f
src/dstf_pkg.sv
src/dstf_ctrl.sv
src/dstf_datapath.sv
src/decimal_string_to_fixed_top.sv
dv/tb_decimal_string_to_fixed_top.sv
